[rtl/pwl_pkg.sv]
// ============================================================================
// PWL package
// Shared types and constants for the piecewise-linear span interpolator.
// ============================================================================
package pwl_pkg;

    localparam int MAX_KNOTS_DEF = 64;
    localparam int HINT_W        = 6;
    localparam int COUNT_W       = 7;
    localparam int DIVIDEND_W    = 64;
    localparam int DIVISOR_W     = 32;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] sample_x;
        logic               use_hint;
        logic               update_hint;
    } pwl_in_t;

    typedef struct packed {
        logic signed [31:0] y_value;
        logic [5:0]         found_span;
        logic               fault;
    } pwl_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pwl_knot_t;

endpackage

[rtl/pwl_mem.sv]
// ============================================================================
// PWL knot memory
// Single write port, single registered read port knot store.
// ============================================================================
module pwl_mem #(
    parameter int DEPTH = pwl_pkg::MAX_KNOTS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  pwl_pkg::pwl_knot_t   wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output pwl_pkg::pwl_knot_t   rdata
);
    import pwl_pkg::*;

    pwl_knot_t mem [DEPTH];
    pwl_knot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pwl_div.sv]
// ============================================================================
// PWL serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module pwl_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pwl_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [pwl_pkg::DIVISOR_W-1:0]     divisor,
    output logic                              done,
    output logic [pwl_pkg::DIVIDEND_W-1:0]    quotient,
    output logic [pwl_pkg::DIVISOR_W-1:0]     remainder
);
    import pwl_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  ge;

    always_comb
    begin
        rem_sh    = {rem_reg, work_reg[DIVIDEND_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? DIVISOR_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

[rtl/pwl_span_interpolator_unit.sv]
// Evaluate beat: hinted linear span search (check, read, compare per step, upward first,
//   then downward), reads of both span knots, multiply, serial divide, rounding and a
//   final state; a zero-width span skips multiply, divide and rounding. Load beat: the
//   knot is written at the accepting edge. item_stall holds from accept until the result
//   is queued; no new item is taken meanwhile. Reset clears the span hint, hint valid
//   flag, knot count (to 2) and result valid; the knot table stays undefined until loaded.
// ============================================================================
// PWL span interpolator unit
// Knot table with hinted linear span search and rounded, saturated interpolation.
// ============================================================================
module pwl_span_interpolator_unit #(
    parameter int MAX_KNOTS = pwl_pkg::MAX_KNOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          knot_count_we,
    input  logic [pwl_pkg::COUNT_W-1:0]   knot_count_wdata,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  pwl_pkg::pwl_in_t              item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output pwl_pkg::pwl_out_t             result
);
    import pwl_pkg::*;

    localparam int IDX_W = $clog2(MAX_KNOTS);
    localparam int CW    = ($clog2(MAX_KNOTS + 1) > COUNT_W) ? $clog2(MAX_KNOTS + 1) : COUNT_W;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_UP_CHK = 14'b00000000000010,
        S_UP_RD  = 14'b00000000000100,
        S_UP_CMP = 14'b00000000001000,
        S_DN_CHK = 14'b00000000010000,
        S_DN_RD  = 14'b00000000100000,
        S_DN_CMP = 14'b00000001000000,
        S_LO_RD  = 14'b00000010000000,
        S_HI_RD  = 14'b00000100000000,
        S_HI_CAP = 14'b00001000000000,
        S_MUL    = 14'b00010000000000,
        S_DIV    = 14'b00100000000000,
        S_RND    = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } state_t;

    function automatic logic [31:0] mag33(input logic [32:0] v);
        mag33 = v[32] ? 32'(-v) : v[31:0];
    endfunction

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    knot_count_reg;
    logic [HINT_W-1:0]     span_hint_reg;
    logic                  hint_valid_reg;
    logic [IDX_W-1:0]      span_reg, last_reg;
    logic signed [31:0]    xs_reg;
    logic                  update_hint_reg;
    logic signed [31:0]    x0_reg, y0_reg;
    logic [31:0]           a_mag_reg, b_mag_reg, d_mag_reg;
    logic                  neg_reg, fault_reg;
    logic [32:0]           qr_reg;
    logic                  sat_reg, neg_eff_reg;
    pwl_out_t              result_reg;
    logic                  result_valid_reg;

    logic                  in_accept;
    logic [CW-1:0]         count_c, last_c, start_c;
    pwl_knot_t             rdata;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DIVISOR_W-1:0]  rem;
    logic [32:0]           a_w, b_w, d_w;
    logic                  ge2, qz;
    logic [33:0]           qr_c;
    logic signed [34:0]    sum_c;
    logic signed [31:0]    y_c;
    logic                  can_load;

    assign item_stall = (state_reg != S_IDLE);
    assign in_accept  = item_valid && !item_stall;
    assign can_load   = !result_valid_reg || !result_stall;

    // clamp count and pick starting span
    always_comb
    begin
        count_c = CW'(knot_count_reg);
        if (count_c < CW'(2))
        begin
            count_c = CW'(2);
        end
        if (count_c > CW'(MAX_KNOTS))
        begin
            count_c = CW'(MAX_KNOTS);
        end
        last_c = count_c - CW'(2);
        if (item.use_hint && hint_valid_reg)
        begin
            start_c = CW'(span_hint_reg);
        end
        else
        begin
            start_c = (count_c >> 1) - CW'(1);
        end
        if (start_c > last_c)
        begin
            start_c = last_c;
        end
    end

    assign mem_we = in_accept && (item.kind == KIND_LOAD) && (32'(item.knot_index) < MAX_KNOTS);

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = span_reg;
        case (state_reg)
            S_UP_RD, S_HI_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(span_reg + 1'b1);
            end
            S_DN_RD, S_LO_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = span_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    pwl_mem #(
        .DEPTH (MAX_KNOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IDX_W'(item.knot_index)),
        .wdata ({item.knot_x, item.knot_y}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign div_start = (state_reg == S_MUL);

    pwl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (DIVIDEND_W'(a_mag_reg) * DIVIDEND_W'(b_mag_reg)),
        .divisor   (d_mag_reg),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    always_comb
    begin
        a_w   = {xs_reg[31], xs_reg} - {x0_reg[31], x0_reg};
        b_w   = {rdata.y[31], rdata.y} - {y0_reg[31], y0_reg};
        d_w   = {rdata.x[31], rdata.x} - {x0_reg[31], x0_reg};
        ge2   = {rem, 1'b0} >= {1'b0, d_mag_reg};
        qr_c  = {1'b0, quot[32:0]} + 34'(ge2);
        qz    = (quot == '0) && !ge2;
        if (neg_eff_reg)
        begin
            sum_c = 35'(signed'({{3{y0_reg[31]}}, y0_reg})) - 35'(signed'({2'b00, qr_reg}));
        end
        else
        begin
            sum_c = 35'(signed'({{3{y0_reg[31]}}, y0_reg})) + 35'(signed'({2'b00, qr_reg}));
        end
        if (fault_reg)
        begin
            y_c = y0_reg;
        end
        else if (sat_reg)
        begin
            y_c = neg_eff_reg ? 32'sh80000000 : 32'sh7fffffff;
        end
        else if (sum_c[34] && (sum_c[33:31] != 3'b111))
        begin
            y_c = 32'sh80000000;
        end
        else if (!sum_c[34] && (sum_c[33:31] != 3'b000))
        begin
            y_c = 32'sh7fffffff;
        end
        else
        begin
            y_c = sum_c[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (item.kind == KIND_EVAL))
                begin
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK: state_next = (span_reg < last_reg) ? S_UP_RD : S_DN_CHK;
            S_UP_RD:  state_next = S_UP_CMP;
            S_UP_CMP: state_next = (xs_reg >= rdata.x) ? S_UP_CHK : S_DN_CHK;
            S_DN_CHK: state_next = (span_reg != '0) ? S_DN_RD : S_LO_RD;
            S_DN_RD:  state_next = S_DN_CMP;
            S_DN_CMP: state_next = (xs_reg < rdata.x) ? S_DN_CHK : S_LO_RD;
            S_LO_RD:  state_next = S_HI_RD;
            S_HI_RD:  state_next = S_HI_CAP;
            S_HI_CAP: state_next = (d_w == '0) ? S_FIN : S_MUL;
            S_MUL:    state_next = S_DIV;
            S_DIV:    state_next = div_done ? S_RND : S_DIV;
            S_RND:    state_next = S_FIN;
            S_FIN:    state_next = can_load ? S_IDLE : S_FIN;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            knot_count_reg   <= COUNT_W'(2);
            span_hint_reg    <= '0;
            hint_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (knot_count_we)
            begin
                knot_count_reg <= knot_count_wdata;
            end
            if ((state_reg == S_LO_RD) && update_hint_reg)
            begin
                span_hint_reg  <= HINT_W'(span_reg);
                hint_valid_reg <= 1'b1;
            end
            if ((state_reg == S_FIN) && can_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                span_reg        <= IDX_W'(start_c);
                last_reg        <= IDX_W'(last_c);
                xs_reg          <= item.sample_x;
                update_hint_reg <= item.update_hint;
            end
            S_UP_CMP:
            begin
                if (xs_reg >= rdata.x)
                begin
                    span_reg <= IDX_W'(span_reg + 1'b1);
                end
            end
            S_DN_CMP:
            begin
                if (xs_reg < rdata.x)
                begin
                    span_reg <= IDX_W'(span_reg - 1'b1);
                end
            end
            S_HI_RD:
            begin
                x0_reg <= rdata.x;
                y0_reg <= rdata.y;
            end
            S_HI_CAP:
            begin
                a_mag_reg <= mag33(a_w);
                b_mag_reg <= mag33(b_w);
                d_mag_reg <= mag33(d_w);
                neg_reg   <= a_w[32] ^ b_w[32] ^ d_w[32];
                fault_reg <= (d_w == '0);
            end
            S_RND:
            begin
                qr_reg      <= qr_c[32:0];
                sat_reg     <= (|quot[63:33]) || qr_c[33];
                neg_eff_reg <= neg_reg && !qz;
            end
            S_FIN:
            begin
                if (can_load)
                begin
                    result_reg.y_value    <= y_c;
                    result_reg.found_span <= 6'(span_reg);
                    result_reg.fault      <= fault_reg;
                end
            end
            default:
            begin
                span_reg <= span_reg;
            end
        endcase
        // a fault skips rounding; keep the add path neutral
        if ((state_reg == S_HI_CAP) && (d_w == '0))
        begin
            neg_eff_reg <= 1'b0;
            sat_reg     <= 1'b0;
            qr_reg      <= '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_span_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (span_reg <= last_reg))
        else $error("span index beyond last span");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (d_mag_reg != '0))
        else $error("divider started with zero span width");

    a_hint_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(hint_valid_reg))
        else $error("hint valid dropped without reset");

endmodule

[tb/tb_pwl_span_interpolator_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// PWL span interpolator unit testbench
// Loads knot tables at many knot counts, evaluates samples inside, on and
// beyond the knots, and checks each result beat against a built-in predictor
// of the span search and rounded, saturated interpolation, while the item
// and result channels idle and stall at random.
// ============================================================================
module tb_pwl_span_interpolator_unit;
    import pwl_pkg::*;

    localparam int     NUM_KNOTS     = MAX_KNOTS_DEF;
    localparam longint CYCLE_LIMIT   = 2000000;
    localparam int     SETTLE_CYCLES = 300;
    localparam longint Q_MIN_L       = -64'sd2147483648;
    localparam longint Q_MAX_L       = 64'sd2147483647;

    class pwl_lut_scoreboard;
        longint   knot_x_tab[NUM_KNOTS];
        longint   knot_y_tab[NUM_KNOTS];
        int       knot_count;
        int       hint_span;
        bit       hint_held;
        pwl_out_t pending[$];
        int       errors;

        function new();
            for (int i = 0; i < NUM_KNOTS; i++)
            begin
                knot_x_tab[i] = 0;
                knot_y_tab[i] = 0;
            end
            knot_count = 2;
            hint_span  = 0;
            hint_held  = 1'b0;
            errors     = 0;
        endfunction

        function void set_count(int value);
            knot_count = value;
        endfunction

        function longint lerp_span(longint xs, longint x0, longint y0, longint x1, longint y1);
            longint    dx;
            longint    dy;
            longint    dw;
            longint    s;
            bit        na;
            bit        nb;
            bit        nd;
            bit        neg;
            bit [63:0] a;
            bit [63:0] b;
            bit [63:0] d;
            bit [63:0] p;
            bit [63:0] q;
            bit [63:0] r;
            dx = xs - x0;
            dy = y1 - y0;
            dw = x1 - x0;
            na = dx < 0;
            nb = dy < 0;
            nd = dw < 0;
            a  = na ? -dx : dx;
            b  = nb ? -dy : dy;
            d  = nd ? -dw : dw;
            p  = a * b;
            q  = p / d;
            r  = p % d;
            if ((r << 1) >= d)
                q = q + 1;
            neg = (na != nb) != nd;
            if (q == 0)
                neg = 1'b0;
            if (q >= 64'h2_0000_0000)
                return neg ? Q_MIN_L : Q_MAX_L;
            s = neg ? y0 - longint'(q) : y0 + longint'(q);
            if (s > Q_MAX_L)
                s = Q_MAX_L;
            if (s < Q_MIN_L)
                s = Q_MIN_L;
            return s;
        endfunction

        function void note_item(pwl_in_t beat);
            int       cnt;
            int       last;
            int       span;
            longint   xs;
            longint   y;
            pwl_out_t res;
            if (beat.kind == KIND_LOAD)
            begin
                knot_x_tab[beat.knot_index] = $signed(beat.knot_x);
                knot_y_tab[beat.knot_index] = $signed(beat.knot_y);
                return;
            end
            cnt = knot_count;
            if (cnt < 2)
                cnt = 2;
            if (cnt > NUM_KNOTS)
                cnt = NUM_KNOTS;
            last = cnt - 2;
            xs   = $signed(beat.sample_x);
            span = (beat.use_hint && hint_held) ? hint_span : cnt / 2 - 1;
            if (span > last)
                span = last;
            while (span < last && xs >= knot_x_tab[span + 1])
                span++;
            while (span > 0 && xs < knot_x_tab[span])
                span--;
            if (beat.update_hint)
            begin
                hint_span = span;
                hint_held = 1'b1;
            end
            if (knot_x_tab[span + 1] == knot_x_tab[span])
            begin
                res.fault = 1'b1;
                y = knot_y_tab[span];
            end
            else
            begin
                res.fault = 1'b0;
                y = lerp_span(xs, knot_x_tab[span], knot_y_tab[span],
                              knot_x_tab[span + 1], knot_y_tab[span + 1]);
            end
            res.y_value    = y[31:0];
            res.found_span = span[5:0];
            pending = {pending, res};
        endfunction

        function void check_result(pwl_out_t got);
            pwl_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got y %h span %0d fault %0b",
                         $time, got.y_value, got.found_span, got.fault);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.y_value !== want.y_value)
            begin
                $display("%0t: y_value mismatch: expected %h, got %h",
                         $time, want.y_value, got.y_value);
                errors++;
            end
            if (got.found_span !== want.found_span)
            begin
                $display("%0t: found_span mismatch: expected %0d, got %0d",
                         $time, want.found_span, got.found_span);
                errors++;
            end
            if (got.fault !== want.fault)
            begin
                $display("%0t: fault mismatch: expected %0b, got %0b",
                         $time, want.fault, got.fault);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               knot_count_we;
    logic [COUNT_W-1:0] knot_count_wdata;
    logic               item_valid;
    logic               item_stall;
    pwl_in_t            item;
    logic               result_valid;
    logic               result_stall;
    pwl_out_t           result;

    pwl_lut_scoreboard  sb;
    int                 sender_idle_pct;
    int                 stall_pct;
    longint             cycle_count;
    longint             tab_x[NUM_KNOTS];

    pwl_span_interpolator_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .knot_count_we    (knot_count_we),
        .knot_count_wdata (knot_count_wdata),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .item             (item),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pwl_span_interpolator_unit regression: fail");
            $finish;
        end
    end

    function automatic longint rand_q();
        return longint'($signed($urandom));
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX_L)
            return Q_MAX_L;
        if (v < Q_MIN_L)
            return Q_MIN_L;
        return v;
    endfunction

    task automatic send_beat(pwl_in_t beat);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item       = beat;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        sb.note_item(beat);
    endtask

    task automatic wait_all_results(int extra);
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_count(int value);
        wait_all_results(8);
        @(negedge clk);
        knot_count_we    = 1'b1;
        knot_count_wdata = value[COUNT_W-1:0];
        @(posedge clk);
        sb.set_count(int'(value[COUNT_W-1:0]));
        @(negedge clk);
        knot_count_we = 1'b0;
    endtask

    task automatic load_knot(int idx, longint x, longint y);
        pwl_in_t beat;
        beat.kind        = KIND_LOAD;
        beat.knot_index  = idx[5:0];
        beat.knot_x      = x[31:0];
        beat.knot_y      = y[31:0];
        beat.sample_x    = $urandom;
        beat.use_hint    = $urandom_range(0, 1);
        beat.update_hint = $urandom_range(0, 1);
        tab_x[idx]       = x;
        send_beat(beat);
    endtask

    task automatic eval_sample(longint sx, bit use_h, bit upd_h);
        pwl_in_t beat;
        beat.kind        = KIND_EVAL;
        beat.knot_index  = $urandom_range(0, 63);
        beat.knot_x      = $urandom;
        beat.knot_y      = $urandom;
        beat.sample_x    = sx[31:0];
        beat.use_hint    = use_h;
        beat.update_hint = upd_h;
        send_beat(beat);
    endtask

    task automatic fill_table(int n);
        int     shape;
        int     bits;
        longint x;
        longint y;
        longint step;
        shape = $urandom_range(0, 9);
        x     = rand_q();
        for (int i = 0; i < n; i++)
        begin
            if (shape == 0)
                x = rand_q();
            else if (shape == 1)
                x = Q_MIN_L + (longint'(i) * 64'sd4294967295) / (n - 1);
            else if (i > 0)
            begin
                bits = $urandom_range(0, 30);
                step = ($urandom_range(0, 11) == 0) ? 0 :
                       longint'($urandom & ((32'h1 << bits) - 1));
                x    = clamp_q(x + step);
            end
            y = rand_q() >>> $urandom_range(0, 16);
            load_knot(i, x, y);
        end
    endtask

    function automatic longint pick_sample(int n);
        int     sel;
        int     k;
        longint lo;
        longint hi;
        longint sx;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, n - 2);
        lo  = tab_x[k];
        hi  = tab_x[k + 1];
        if (sel < 50)
            sx = (hi > lo) ? lo + (longint'({$urandom, $urandom} >> 1) % (hi - lo)) : lo;
        else if (sel < 60)
            sx = tab_x[$urandom_range(0, n - 1)];
        else if (sel < 70)
            sx = tab_x[0] - longint'($urandom_range(0, 1) ? $urandom_range(1, 32'hFFFFF)
                                                          : $urandom);
        else if (sel < 80)
            sx = tab_x[n - 1] + longint'($urandom_range(0, 1) ? $urandom_range(1, 32'hFFFFF)
                                                              : $urandom);
        else if (sel < 92)
            sx = rand_q();
        else
            sx = $urandom_range(0, 1) ? Q_MIN_L : Q_MAX_L;
        return clamp_q(sx);
    endfunction

    initial
    begin
        int count_plan[20];
        int eff;
        int n_evals;
        int idx;
        count_plan = '{3, 2, 64, 0, 5, 1, 8, 127, 4, 16, 65, 6, 2, 10, 3, 7, 33, 12, 2, 5};
        sb               = new();
        cycle_count      = 0;
        sender_idle_pct  = 0;
        stall_pct        = 0;
        rst_n            = 1'b0;
        knot_count_we    = 1'b0;
        knot_count_wdata = '0;
        item_valid       = 1'b0;
        item             = '0;
        for (int i = 0; i < NUM_KNOTS; i++)
            tab_x[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, saturation, rounding ties, zero width, unsorted
        write_count(2);
        load_knot(0, Q_MIN_L, Q_MIN_L);
        load_knot(1, Q_MAX_L, Q_MAX_L);
        eval_sample(Q_MIN_L, 1'b0, 1'b0);
        eval_sample(Q_MAX_L, 1'b0, 1'b1);
        eval_sample(0, 1'b1, 1'b0);
        load_knot(1, Q_MIN_L, 5);
        eval_sample(12345, 1'b0, 1'b0);
        load_knot(0, 0, Q_MIN_L);
        load_knot(1, 65536, Q_MAX_L);
        eval_sample(Q_MAX_L, 1'b0, 1'b0);
        eval_sample(Q_MIN_L, 1'b0, 1'b0);
        eval_sample(32768, 1'b0, 1'b0);
        load_knot(0, 0, 0);
        load_knot(1, 2, -1);
        eval_sample(1, 1'b0, 1'b0);
        load_knot(0, 6553600, 7);
        load_knot(1, -6553600, 9);
        eval_sample(0, 1'b0, 1'b0);

        // hint left beyond the last span after the count shrinks
        write_count(4);
        load_knot(0, 0, 0);
        load_knot(1, 65536, 65536);
        load_knot(2, 131072, 262144);
        load_knot(3, 196608, 589824);
        eval_sample(163840, 1'b0, 1'b1);
        write_count(2);
        eval_sample(32768, 1'b1, 1'b0);

        for (int ph = 0; ph < 20; ph++)
        begin
            write_count(count_plan[ph]);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 65; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 65; end
                default: begin sender_idle_pct = 33; stall_pct = 33; end
            endcase
            eff = count_plan[ph];
            if (eff < 2)
                eff = 2;
            if (eff > NUM_KNOTS)
                eff = NUM_KNOTS;
            fill_table(eff);
            n_evals = $urandom_range(30, 50);
            for (int j = 0; j < n_evals; j++)
            begin
                // hold the sender until the block has drained
                if (j == n_evals / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    wait_all_results(0);
                if ($urandom_range(0, 9) == 0)
                begin
                    idx = $urandom_range(0, NUM_KNOTS - 1);
                    load_knot(idx, $urandom_range(0, 1) ? tab_x[idx] : rand_q(), rand_q());
                end
                else
                    eval_sample(pick_sample(eff), $urandom_range(0, 3) != 0,
                                $urandom_range(0, 1));
            end
        end

        wait_all_results(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("pwl_span_interpolator_unit regression: pass");
        else
            $display("pwl_span_interpolator_unit regression: fail");
        $finish;
    end

endmodule
